[rtl/imufd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imufd_pkg
// Shared types, constants and the byte-wide CRC-16 step of the deframer.
// ----------------------------------------------------------------------------
package imufd_pkg;

  localparam logic [7:0]  SYNC_FIRST      = 8'h5A;
  localparam logic [7:0]  SYNC_SECOND     = 8'hA5;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd506;

  // One result item as it leaves the parser.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_data;
    logic [15:0] payload_index;
    logic        frame_last;
    logic        crc_match;
    logic [15:0] frame_length;
    logic        length_error;
  } result_t;

  // CRC-16, poly 0x1021, MSB first, one byte unrolled over eight bit steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/imu_frame_deframer_crc16_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imu_frame_deframer_crc16_core
// Sync/length/CRC-16 deframer for a received serial byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per transfer. The block hunts for the
//   sync pair 0x5A 0xA5, reads a little-endian 16-bit length and 16-bit CRC,
//   then emits one m_axis transfer per payload byte. tlast marks the frame
//   end, where tuser[1] tells whether the CRC-16 (poly 0x1021, init 0) over
//   sync, length and payload matches the received CRC. A length above the
//   max register gives a single transfer with tuser[2] set and the frame is
//   dropped; a zero length gives a single tlast transfer with no payload.
//   Header bytes produce no transfer.
//   Each byte is held in the input register, then its result in the result register.
//   Throughput: one byte per cycle while m_axis does not stall, set by the
//   CRC byte step feeding the result register.
//   Reset clears the hunt state and sets the max length to 506.
//   When m_axis stalls, the result register holds and the input register
//   fills; s_axis_tready then drops until the result is taken.
//   cfg carries max_payload_len; write it only while the block is idle.
// ----------------------------------------------------------------------------
module imu_frame_deframer_crc16_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] payload_data, [23:8] payload_index,
                                           // [39:24] frame_length
  output logic [2:0]       m_axis_tuser,   // [0] payload_valid, [1] crc_match,
                                           // [2] length_error
  output logic             m_axis_tlast,   // frame_last
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i      // max_payload_len
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               out_free;
  logic               step;
  logic               res_valid;
  imufd_pkg::result_t res;
  imufd_pkg::result_t out_res;

  assign step        = in_valid && out_free;
  assign cfg_ready_o = 1'b1;

  imufd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .take_i     (step),
    .valid_o    (in_valid),
    .data_o     (in_byte)
  );

  imufd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  imufd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.frame_length, out_res.payload_index, out_res.payload_data};
  assign m_axis_tuser = {out_res.length_error, out_res.crc_match, out_res.payload_valid};
  assign m_axis_tlast = out_res.frame_last;

endmodule
`default_nettype wire

[rtl/imufd_in_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imufd_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module imufd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_data_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      data_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

[rtl/imufd_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imufd_parser
// Sync hunt, header capture, payload count and CRC check, one byte per step.
// ----------------------------------------------------------------------------
module imufd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_data_i,
  output logic               res_valid_o,
  output imufd_pkg::result_t res_o
);

  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_LEN_LO  = 3'd1;
  localparam logic [2:0] ST_LEN_HI  = 3'd2;
  localparam logic [2:0] ST_CRC_LO  = 3'd3;
  localparam logic [2:0] ST_CRC_HI  = 3'd4;
  localparam logic [2:0] ST_PAYLOAD = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [7:0]  prev_q, prev_d;
  logic [15:0] len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] max_len_q;
  logic [15:0] crc_next;
  logic [15:0] rcrc_full;
  logic [16:0] idx_inc;

  assign crc_next  = imufd_pkg::crc16_byte(crc_q, byte_i);
  assign rcrc_full = {byte_i, rcrc_q[7:0]};
  assign idx_inc   = {1'b0, idx_q} + 17'd1;

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    len_d       = len_q;
    crc_d       = crc_q;
    rcrc_d      = rcrc_q;
    idx_d       = idx_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_q)
      ST_HUNT: begin
        prev_d = byte_i;
        if (prev_q == imufd_pkg::SYNC_FIRST && byte_i == imufd_pkg::SYNC_SECOND) begin
          // restart the CRC over the two sync bytes
          crc_d   = imufd_pkg::crc16_byte(imufd_pkg::crc16_byte(16'h0000,
                      imufd_pkg::SYNC_FIRST), imufd_pkg::SYNC_SECOND);
          state_d = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        crc_d      = crc_next;
        len_d[7:0] = byte_i;
        state_d    = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        crc_d       = crc_next;
        len_d[15:8] = byte_i;
        state_d     = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        rcrc_d[7:0] = byte_i;
        state_d     = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        rcrc_d = rcrc_full;
        if (len_q > max_len_q) begin
          // drop the frame and report the bad length
          res_valid_o        = 1'b1;
          res_o.frame_length = len_q;
          res_o.length_error = 1'b1;
          state_d            = ST_HUNT;
        end else if (len_q == 16'd0) begin
          res_valid_o      = 1'b1;
          res_o.frame_last = 1'b1;
          res_o.crc_match  = (crc_q == rcrc_full);
          state_d          = ST_HUNT;
        end else begin
          idx_d   = 16'd0;
          state_d = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        crc_d               = crc_next;
        res_valid_o         = 1'b1;
        res_o.payload_valid = 1'b1;
        res_o.payload_data  = byte_i;
        res_o.payload_index = idx_q;
        res_o.frame_length  = len_q;
        if (idx_inc >= {1'b0, len_q}) begin
          res_o.frame_last = 1'b1;
          res_o.crc_match  = (crc_next == rcrc_q);
          state_d          = ST_HUNT;
        end else begin
          idx_d = idx_inc[15:0];
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      prev_q  <= 8'h00;
      len_q   <= 16'h0000;
      crc_q   <= 16'h0000;
      rcrc_q  <= 16'h0000;
      idx_q   <= 16'h0000;
    end else if (step_i) begin
      state_q <= state_d;
      prev_q  <= prev_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
      rcrc_q  <= rcrc_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= imufd_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  a_payload_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAYLOAD |-> idx_q < len_q)
    else $error("payload index reached the header length");

  a_len_error_resumes_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && state_q == ST_CRC_HI && len_q > max_len_q |=> state_q == ST_HUNT)
    else $error("oversized frame did not resume hunting");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.frame_last |=> state_q == ST_HUNT)
    else $error("frame end did not return to hunting");

endmodule
`default_nettype wire

[rtl/imufd_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// imufd_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module imufd_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire imufd_pkg::result_t  res_i,
  output logic                     free_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output imufd_pkg::result_t       res_o
);

  logic               valid_q, valid_d;
  imufd_pkg::result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire
